@@ rtl/bqsp_pkg.sv @@
// shared types, constants and the escape table for the backtick quoted string parser
// no dependencies; used by every module in rtl/
package bqsp_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKTICK = 8'h60;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       is_end;
        logic       accepted;
    } result_t;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_QUOTE,
        CLS_BACKTICK
    } byte_class_t;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic [7:0]  raw_byte;
        logic        is_last;
        byte_class_t cls;
        logic        esc_ok;
        logic [7:0]  esc_byte;
    } token_t;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_BODY,
        PH_ESC,
        PH_CLOSED,
        PH_FAIL
    } phase_t;

    typedef struct packed {
        logic ok;
        logic [7:0] value;
    } esc_map_t;

    function automatic esc_map_t unescape(input logic [7:0] c);
        esc_map_t m;
        m.ok    = 1'b1;
        m.value = 8'h00;
        case (c)
            8'h22:   m.value = 8'h22;
            8'h60:   m.value = 8'h60;
            8'h28:   m.value = 8'h7B;
            8'h29:   m.value = 8'h7D;
            8'h2E:   m.value = 8'h2C;
            8'h3A:   m.value = 8'h3B;
            8'h2F:   m.value = 8'h5C;
            default: m.ok    = 1'b0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/bqsp_front.sv @@
// front end: takes input words and classifies each byte for the parser back end
// depends on bqsp_pkg
module bqsp_front
    import bqsp_pkg::*;
(
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output logic   push,
    output token_t push_tok,
    input  logic   q_full
);

    esc_map_t esc;

    always_comb
    begin
        esc = unescape(item.in_byte);
        push_tok.raw_byte = item.in_byte;
        push_tok.is_last  = item.is_last;
        push_tok.esc_ok   = esc.ok;
        push_tok.esc_byte = esc.value;
        if (item.in_byte == CH_QUOTE)
        begin
            push_tok.cls = CLS_QUOTE;
        end
        else if (item.in_byte == CH_BACKTICK)
        begin
            push_tok.cls = CLS_BACKTICK;
        end
        else
        begin
            push_tok.cls = CLS_OTHER;
        end
    end

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

endmodule

@@ rtl/bqsp_queue.sv @@
// small token queue between the front and back ends
// depends on bqsp_pkg
module bqsp_queue
    import bqsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_tok,
    input  logic   pop,
    output logic   q_valid,
    output logic   q_full,
    output token_t head_tok
);

    token_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    assign q_valid  = (count_reg != '0);
    assign q_full   = (count_reg == QCW'(QDEPTH));
    assign head_tok = mem_reg[rd_ptr_reg];

endmodule

@@ rtl/bqsp_back.sv @@
// back end: phase state machine over classified tokens and the output register
// depends on bqsp_pkg
module bqsp_back
    import bqsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  token_t  head_tok,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    phase_t  phase_reg, phase_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    phase_t  parsed;
    logic    emit;
    logic [7:0] ob;
    logic    can_load;

    assign can_load = !out_valid_reg || !result_stall;
    assign pop      = q_valid && can_load;

    always_comb
    begin
        emit   = 1'b0;
        ob     = 8'h00;
        parsed = PH_FAIL;
        case (phase_reg)
            PH_OPEN:
            begin
                parsed = (head_tok.cls == CLS_QUOTE) ? PH_BODY : PH_FAIL;
            end
            PH_BODY:
            begin
                if (head_tok.cls == CLS_QUOTE)
                begin
                    parsed = PH_CLOSED;
                end
                else if (head_tok.cls == CLS_BACKTICK)
                begin
                    parsed = PH_ESC;
                end
                else
                begin
                    parsed = PH_BODY;
                    emit   = 1'b1;
                    ob     = head_tok.raw_byte;
                end
            end
            PH_ESC:
            begin
                if (head_tok.esc_ok)
                begin
                    parsed = PH_BODY;
                    emit   = 1'b1;
                    ob     = head_tok.esc_byte;
                end
            end
            default:
            begin
                parsed = PH_FAIL;
            end
        endcase

        phase_next     = phase_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            // last byte closes the string and rearms for the next one
            phase_next         = head_tok.is_last ? PH_OPEN : parsed;
            out_valid_next     = emit || head_tok.is_last;
            out_next.has_byte  = emit;
            out_next.out_byte  = ob;
            out_next.is_end    = head_tok.is_last;
            out_next.accepted  = head_tok.is_last && (parsed == PH_CLOSED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ rtl/backtick_quoted_string_parser.sv @@
// top level of the backtick quoted string parser: front end, token queue, back end
// depends on bqsp_pkg, bqsp_front, bqsp_queue and bqsp_back
//
// usage:
// - item channel (item_valid, item_stall, item) carries one byte of a string per word,
//   with is_last set on the final byte of each string
// - result channel (result_valid, result_stall, result) gives one word per body byte
//   emitted, plus one end word (is_end set) per string with the accept verdict;
//   a plain body byte on the last input rides on the end word
// - emitted bytes are tentative until the end word says accepted
// - throughput is one byte per cycle while result_stall is low, set by the phase update
//   in the back end; an accepted input word is registered in the four-entry token queue,
//   then in the output register, before its result word appears
// - when result_stall is high the output word holds; the queue absorbs up to four more
//   bytes before item_stall rises
// - reset empties the queue, drops any pending result and rearms the parser for
//   an opening quote
module backtick_quoted_string_parser
    import bqsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic   push;
    logic   pop;
    logic   q_valid;
    logic   q_full;
    token_t push_tok;
    token_t head_tok;

    bqsp_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_tok   (push_tok),
        .q_full     (q_full)
    );

    bqsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head_tok (head_tok)
    );

    bqsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head_tok     (head_tok),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ test/tb.sv @@
// testbench for backtick_quoted_string_parser: directed strings, then random quoted and broken
// strings with random gaps and stalls on both channels; depends on bqsp_pkg and the rtl
module tb
    import bqsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;
    localparam int WELLFORMED_WORDS = 1300;
    localparam int BROKEN_WORDS = 550;

    // escape letters and what they stand for
    localparam logic [7:0] LT_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] LT_CLOSE_PAREN = 8'h29;
    localparam logic [7:0] LT_PERIOD      = 8'h2E;
    localparam logic [7:0] LT_COLON       = 8'h3A;
    localparam logic [7:0] LT_SLASH       = 8'h2F;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA       = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON   = 8'h3B;
    localparam logic [7:0] CH_BACKSLASH   = 8'h5C;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    phase_t     parse_state = PH_OPEN;
    result_t    unescaped_words[$];
    logic [7:0] text[$];
    int         error_count = 0;
    int         words_sent = 0;
    int         sender_calm = 0;
    int         receiver_calm = 0;
    int         idle_cycles = 0;

    backtick_quoted_string_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic bit map_escape(input logic [7:0] c, output logic [7:0] v);
        v = 8'h00;
        case (c)
            CH_QUOTE:       v = CH_QUOTE;
            CH_BACKTICK:    v = CH_BACKTICK;
            LT_OPEN_PAREN:  v = CH_OPEN_BRACE;
            LT_CLOSE_PAREN: v = CH_CLOSE_BRACE;
            LT_PERIOD:      v = CH_COMMA;
            LT_COLON:       v = CH_SEMICOLON;
            LT_SLASH:       v = CH_BACKSLASH;
            default:        return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // advances the parse phase by one word; returns 1 when the word gives a result
    function automatic bit parse_word(input item_t w, output result_t r);
        phase_t     nxt;
        logic       emit;
        logic [7:0] v;
        emit = 1'b0;
        v = 8'h00;
        r = '0;
        case (parse_state)
            PH_OPEN:
                nxt = (w.in_byte == CH_QUOTE) ? PH_BODY : PH_FAIL;
            PH_BODY:
            begin
                if (w.in_byte == CH_QUOTE)
                    nxt = PH_CLOSED;
                else if (w.in_byte == CH_BACKTICK)
                    nxt = PH_ESC;
                else
                begin
                    nxt = PH_BODY;
                    emit = 1'b1;
                    v = w.in_byte;
                end
            end
            PH_ESC:
            begin
                if (map_escape(w.in_byte, v))
                begin
                    nxt = PH_BODY;
                    emit = 1'b1;
                end
                else
                    nxt = PH_FAIL;
            end
            default:
                nxt = PH_FAIL;
        endcase
        r.has_byte = emit;
        r.out_byte = emit ? v : 8'h00;
        if (w.is_last)
        begin
            r.is_end = 1'b1;
            r.accepted = (nxt == PH_CLOSED);
            parse_state = PH_OPEN;
            return 1'b1;
        end
        parse_state = nxt;
        return emit;
    endfunction

    // random wait with occasional runs of back-to-back words
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] escape_letter(input int k);
        case (k)
            0:       return CH_QUOTE;
            1:       return CH_BACKTICK;
            2:       return LT_OPEN_PAREN;
            3:       return LT_CLOSE_PAREN;
            4:       return LT_PERIOD;
            5:       return LT_COLON;
            default: return LT_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_QUOTE || b == CH_BACKTICK);
        return b;
    endfunction

    function automatic logic [7:0] bad_letter();
        logic [7:0] b;
        logic [7:0] unused;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end while (map_escape(b, unused));
        return b;
    endfunction

    // bytes that steer the parser, mixed with anything
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return CH_QUOTE;
            1:       return CH_BACKTICK;
            2:       return escape_letter($urandom_range(0, 6));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // appends one byte to the string being built
    function automatic void add_byte(input logic [7:0] b);
        text.insert(text.size(), b);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        int      gap;
        item_t   w;
        result_t r;
        gap = draw_wait(sender_calm);
        w.in_byte = b;
        w.is_last = last;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do
        begin
            @(posedge clk);
        end while (item_stall);
        words_sent++;
        if (parse_word(w, r))
            unescaped_words.insert(unescaped_words.size(), r);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_word(text[i], i == text.size() - 1);
    endtask

    task automatic add_body();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 7)
                add_byte(plain_byte());
            else
            begin
                add_byte(CH_BACKTICK);
                add_byte(escape_letter($urandom_range(0, 6)));
            end
        end
    endtask

    task automatic build_quoted();
        text.delete();
        add_byte(CH_QUOTE);
        add_body();
        add_byte(CH_QUOTE);
    endtask

    task automatic test_directed_cases();
        // every escape, plus the lowest and highest plain bytes
        text.delete();
        add_byte(CH_QUOTE);
        add_byte(8'h00);
        for (int k = 0; k < 7; k++)
        begin
            add_byte(CH_BACKTICK);
            add_byte(escape_letter(k));
        end
        add_byte(8'hFF);
        add_byte(CH_QUOTE);
        send_text();
        // missing opening quote on a one-word string
        text = '{"x"};
        send_text();
        // bad escape, rest of the string consumed silently
        text = '{CH_QUOTE, CH_BACKTICK, "q", CH_QUOTE};
        send_text();
        // trailing word after the closing quote
        text = '{CH_QUOTE, CH_QUOTE, 8'h00};
        send_text();
        // missing closing quote, plain byte rides on the end word
        text = '{CH_QUOTE, 8'hFF};
        send_text();
        // string ends right after a backtick
        text = '{CH_QUOTE, CH_BACKTICK};
        send_text();
    endtask

    task automatic test_wellformed_strings();
        int start;
        start = words_sent;
        while (words_sent - start < WELLFORMED_WORDS)
        begin
            build_quoted();
            send_text();
        end
    endtask

    task automatic test_broken_strings();
        int start;
        int cut;
        start = words_sent;
        while (words_sent - start < BROKEN_WORDS)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    build_quoted();
                    do
                    begin
                        text[0] = noise_byte();
                    end while (text[0] == CH_QUOTE);
                end
                1:
                begin
                    text.delete();
                    add_byte(CH_QUOTE);
                    add_body();
                    add_byte(CH_BACKTICK);
                    add_byte(bad_letter());
                    add_body();
                    add_byte(CH_QUOTE);
                end
                2:
                begin
                    build_quoted();
                    repeat ($urandom_range(1, 4)) add_byte(noise_byte());
                end
                3:
                begin
                    build_quoted();
                    cut = $urandom_range(1, text.size() - 1);
                    repeat (cut) void'(text.pop_back());
                end
                4:
                begin
                    text.delete();
                    add_byte(CH_QUOTE);
                    add_body();
                    add_byte(CH_BACKTICK);
                end
                default:
                begin
                    text.delete();
                    repeat ($urandom_range(1, 8)) add_byte(noise_byte());
                end
            endcase
            send_text();
        end
    endtask

    // result side stall, drawn anew for every word
    initial
    begin : drive_result_stall
        int n;
        forever
        begin
            @(negedge clk);
            n = draw_wait(receiver_calm);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
                result_stall <= 1'b0;
            end
            do
            begin
                @(posedge clk);
            end while (!(result_valid && !result_stall));
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (unescaped_words.size() == 0)
            begin
                $error("unexpected result word: %h", result);
                error_count++;
            end
            else
            begin
                want = unescaped_words.pop_front();
                if (result.has_byte !== want.has_byte)
                begin
                    $error("has_byte: expected %0d, got %0d", want.has_byte, result.has_byte);
                    error_count++;
                end
                if (result.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
                    error_count++;
                end
                if (result.is_end !== want.is_end)
                begin
                    $error("is_end: expected %0d, got %0d", want.is_end, result.is_end);
                    error_count++;
                end
                if (result.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", want.accepted, result.accepted);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(item_valid && !item_stall) && !(result_valid && !result_stall))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_wellformed_strings();
        test_broken_strings();

        @(negedge clk);
        item_valid <= 1'b0;
        while (unescaped_words.size() > 0)
            @(posedge clk);
        // catch any stray word after the last expected one
        repeat (8) @(posedge clk);
        if (unescaped_words.size() != 0)
        begin
            $error("%0d expected words never arrived", unescaped_words.size());
            error_count++;
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
